[rtl/crvn_pkg.sv]
// ----------------------------------------------------------------------------
// crvn_pkg - shared constants for the Catmull-Rom value noise block
// Fixed widths of the request and result fields.
// ----------------------------------------------------------------------------
package crvn_pkg;
	localparam int TABLE_SIZE = 256;
	localparam int FRAC_BITS  = 16;
	localparam int CELL_W = $clog2(TABLE_SIZE);
	localparam int OUT_W  = FRAC_BITS + 4;
	localparam int CFG_W  = 3;
	// 2^F = LEAF_Q * (TABLE_SIZE-1) + 1 for this table size and fraction width,
	// so a leaf is m*LEAF_Q plus one rounding bit, no divider
	localparam int LEAF_Q = (1 << FRAC_BITS) / (TABLE_SIZE - 1);
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;
endpackage

[rtl/catmull_rom_value_noise.sv]
// ----------------------------------------------------------------------------
// catmull_rom_value_noise - multi-dimensional value noise evaluator
// Permutation-table walk with Catmull-Rom interpolation per dimension,
// computed on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// channel | signals                                   | dir
// in      | in_valid/in_ready, mode .. frac_3         | request in
// out     | out_valid/out_ready, noise_value          | result out
// cfg     | cfg_we, cfg_wdata (dimensions_in_use)     | write only
//
// A load request leaves the block in ST_IDLE; in_ready stays high, so loads go back to back.
// An evaluate request with d dims: each table read passes ST_DESC and ST_RDWAIT,
// each leaf ST_LEAF, each return ST_RET, each cubic ST_COEF, ST_MUL/ST_ACC (3 passes
// on the shared multiplier) and ST_FIN; out_valid rises in ST_OUT.
// After the result is taken the block returns to ST_IDLE for the next request.
// Reset sets only state_q, dims_q (to 2) and out_valid; the table is undefined until loaded.
// in_ready is low while a request is busy or a result waits to be taken.
// ----------------------------------------------------------------------------
module catmull_rom_value_noise #(
	parameter int MAX_DIMS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [crvn_pkg::CFG_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [crvn_pkg::CELL_W-1:0] load_address,
	input  logic [crvn_pkg::CELL_W-1:0] load_value,
	input  logic [crvn_pkg::CELL_W-1:0] start_index,
	input  logic [crvn_pkg::CELL_W-1:0] cell_0,
	input  logic [crvn_pkg::CELL_W-1:0] cell_1,
	input  logic [crvn_pkg::CELL_W-1:0] cell_2,
	input  logic [crvn_pkg::CELL_W-1:0] cell_3,
	input  logic [crvn_pkg::FRAC_BITS-1:0] frac_0,
	input  logic [crvn_pkg::FRAC_BITS-1:0] frac_1,
	input  logic [crvn_pkg::FRAC_BITS-1:0] frac_2,
	input  logic [crvn_pkg::FRAC_BITS-1:0] frac_3,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [crvn_pkg::OUT_W-1:0] noise_value
);
	import crvn_pkg::*;

	localparam int AW = CELL_W;
	localparam int VW = OUT_W;                    // Q3.F value
	localparam int TW = VW + 6;                   // Horner accumulator
	localparam int PW = TW + FRAC_BITS + 1;       // product
	localparam int LW = $clog2(MAX_DIMS + 1);
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int SD = 4 * (MAX_DIMS + 1);
	localparam int SW = $clog2(SD);
	localparam logic signed [VW-1:0] SAT_HI = {2'b00, {(VW-2){1'b1}}};
	localparam logic signed [VW-1:0] SAT_LO = {2'b11, {(VW-2){1'b0}}};

	localparam logic [3:0] ST_IDLE = 4'd0, ST_DESC = 4'd1, ST_RDWAIT = 4'd2,
		ST_LEAF = 4'd3, ST_RET = 4'd4, ST_COEF = 4'd5, ST_MUL = 4'd6,
		ST_ACC = 4'd7, ST_FIN = 4'd8, ST_OUT = 4'd9;

	logic [3:0] state_q;
	logic [CFG_W-1:0] dims_q;
	logic [AW-1:0] perm_mem [TABLE_SIZE];
	logic [AW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] leaf_q;
	logic [CELL_W-1:0] cell_q [4];
	logic [CELL_W-1:0] cell_in [4];
	logic [FRAC_BITS-1:0] frac_q [4];
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] top_q;
	logic [1:0] j_q [MAX_DIMS+1];
	logic [AW-1:0] base_q [MAX_DIMS+1];
	logic signed [VW-1:0] stk_q [SD];
	logic signed [VW-1:0] ret_q;
	logic signed [TW-1:0] t_q, b_q, c_q, d_q;
	logic [1:0] step_q;
	logic signed [PW-1:0] prod_q;
	logic [LW-1:0] top_lvl;
	logic [CELL_W-1:0] top_cell;
	logic [AW-1:0] leaf_m;
	logic [VW-1:0] leaf_mag;
	logic signed [VW-1:0] leaf_val;

	assign top_lvl = (dims_q > CFG_W'(MAX_DIMS)) ? LW'(MAX_DIMS) : LW'(dims_q);
	assign in_ready = (state_q == ST_IDLE);

	// cell of the top level, straight from the request
	assign cell_in = '{cell_0, cell_1, cell_2, cell_3};
	assign top_cell = cell_in[2'(top_lvl - LW'(1))];

	// table address of neighbor j at level lvl_q
	always_comb begin
		rd_addr = AW'(base_q[lvl_q] + AW'(j_q[lvl_q]) - AW'(1));
	end

	// leaf: |TABLE_SIZE-1-2i| is the odd m below, value m*LEAF_Q + (m >= half)
	assign leaf_m = leaf_q[AW-1] ? {leaf_q[AW-2:0], 1'b1} : ~{leaf_q[AW-2:0], 1'b0};
	assign leaf_mag = VW'(leaf_m) * VW'(LEAF_Q) + VW'(leaf_m[AW-1]);
	assign leaf_val = leaf_q[AW-1] ? -$signed(leaf_mag) : $signed(leaf_mag);

	function automatic logic [SW-1:0] sidx(input logic [LW-1:0] l, input logic [1:0] j);
		return SW'({l, j});
	endfunction

	function automatic logic signed [VW-1:0] sat(input logic signed [TW-1:0] v);
		if (v > TW'(SAT_HI)) return SAT_HI;
		if (v < TW'(SAT_LO)) return SAT_LO;
		return VW'(v);
	endfunction

	// rounded shift by FRAC_BITS, half away from zero
	function automatic logic signed [TW-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] m;
		m = (p < 0) ? -p : p;
		m = (m + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return (p < 0) ? -TW'(m) : TW'(m);
	endfunction

	// cell used when descending from level l+1 to l
	function automatic logic [CELL_W-1:0] crvn_cell(input logic [LW-1:0] l);
		return cell_q[2'(l - LW'(1))];
	endfunction

	logic signed [TW-1:0] k0, k1, k2, k3;
	logic [DW-1:0] dsel;
	assign dsel = DW'(lvl_q);
	always_comb begin
		k0 = TW'(stk_q[sidx(lvl_q, 2'd0)]);
		k1 = TW'(stk_q[sidx(lvl_q, 2'd1)]);
		k2 = TW'(stk_q[sidx(lvl_q, 2'd2)]);
		k3 = TW'(stk_q[sidx(lvl_q, 2'd3)]);
	end

	logic signed [TW-1:0] t_half;
	logic signed [TW-1:0] t_abs;
	always_comb begin
		t_abs = (t_q < 0) ? -t_q : t_q;
		t_abs = (t_abs + TW'(1)) >>> 1;
		t_half = (t_q < 0) ? -t_abs : t_abs;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && mode == MODE_LOAD)
			perm_mem[AW'(load_address)] <= AW'(load_value);
		rd_q <= perm_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dims_q    <= CFG_W'(2);
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				dims_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && mode == MODE_EVAL) begin
						cell_q <= '{cell_0, cell_1, cell_2, cell_3};
						frac_q <= '{frac_0, frac_1, frac_2, frac_3};
						lvl_q  <= top_lvl;
						top_q  <= top_lvl;
						j_q[top_lvl] <= 2'd0;
						if (top_lvl == '0) begin
							leaf_q  <= AW'(start_index);
							state_q <= ST_LEAF;
						end else begin
							base_q[top_lvl] <= AW'(AW'(start_index) + AW'(top_cell));
							state_q <= ST_DESC;
						end
					end
				end
				ST_DESC: state_q <= ST_RDWAIT;   // table read in flight
				ST_RDWAIT: begin
					if (lvl_q == LW'(1)) begin
						leaf_q  <= rd_q;
						state_q <= ST_LEAF;
					end else begin
						lvl_q <= lvl_q - LW'(1);
						j_q[lvl_q - LW'(1)] <= 2'd0;
						base_q[lvl_q - LW'(1)] <= AW'(rd_q + AW'(crvn_cell(lvl_q - LW'(1))));
						state_q <= ST_DESC;
					end
				end
				ST_LEAF: begin
					ret_q   <= leaf_val;
					state_q <= ST_RET;
				end
				ST_RET: begin
					if (top_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						stk_q[sidx(lvl_q, j_q[lvl_q])] <= ret_q;
						if (j_q[lvl_q] == 2'd3) begin
							state_q <= ST_COEF;
						end else begin
							j_q[lvl_q] <= j_q[lvl_q] + 2'd1;
							state_q <= ST_DESC;
						end
					end
				end
				ST_COEF: begin
					t_q <= TW'(3) * (k1 - k2) + (k3 - k0);
					b_q <= TW'(2) * k0 - TW'(5) * k1 + TW'(4) * k2 - k3;
					c_q <= k2 - k0;
					d_q <= TW'(2) * k1;
					step_q <= 2'd0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= PW'(t_q) * $signed({1'b0, frac_q[dsel - DW'(1)]});
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (step_q)
						2'd0: t_q <= rnd(prod_q) + b_q;
						2'd1: t_q <= rnd(prod_q) + c_q;
						default: t_q <= rnd(prod_q) + d_q;
					endcase
					step_q <= step_q + 2'd1;
					state_q <= (step_q == 2'd2) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					ret_q <= sat(t_half);
					if (lvl_q == top_q) begin
						state_q <= ST_OUT;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						state_q <= ST_RET;
					end
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign noise_value = ret_q;
endmodule

[rtl/crvn_checker.sv]
// ----------------------------------------------------------------------------
// crvn_checker - port-level checks for catmull_rom_value_noise
// Handshake and result ordering seen at the ports.
// ----------------------------------------------------------------------------
module crvn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready with pending result");
	a_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result repeated");
endmodule

bind catmull_rom_value_noise crvn_checker u_crvn_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for catmull_rom_value_noise
// Loads the permutation table, then sends evaluate requests over several
// dimension settings with random gaps and stalls on both channels.
// An internal noise predictor produces the expected values, and each result
// is compared with them in order.
// ----------------------------------------------------------------------------
module tb_top;
	import crvn_pkg::*;

	localparam int FB = 16;
	localparam longint SAT_HI = (64'sd1 <<< (FB + 3)) - 1;
	localparam longint SAT_LO = -(64'sd1 <<< (FB + 3));
	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_LOAD;
	logic [CELL_W-1:0] load_address = '0, load_value = '0, start_index = '0;
	logic [CELL_W-1:0] cell_0 = '0, cell_1 = '0, cell_2 = '0, cell_3 = '0;
	logic [FB-1:0] frac_0 = '0, frac_1 = '0, frac_2 = '0, frac_3 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [FB+3:0] noise_value;

	// predictor state
	logic [7:0] perm_copy [256];
	logic [2:0] dims_reg = 3'd2;
	logic [7:0] cur_cell [4];
	longint cur_frac [4];

	logic signed [FB+3:0] expected_noise [$];
	bit failed = 0;
	int cycles = 0;
	bit hold_off = 0;

	always #5 clk = ~clk;

	catmull_rom_value_noise dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.load_address(load_address), .load_value(load_value),
		.start_index(start_index), .cell_0(cell_0), .cell_1(cell_1),
		.cell_2(cell_2), .cell_3(cell_3), .frac_0(frac_0), .frac_1(frac_1),
		.frac_2(frac_2), .frac_3(frac_3), .out_valid(out_valid),
		.out_ready(out_ready), .noise_value(noise_value)
	);

	// --- predictor -----------------------------------------------------------
	function automatic longint sat3(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// shift right, rounding half away from zero
	function automatic longint rshift_round(longint v, int s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint leaf_level(int i);
		longint num;
		num = longint'(255 - 2 * i) * 65536;
		if (num >= 0) return sat3((num + 127) / 255);
		return sat3(-((-num + 127) / 255));
	endfunction

	// Catmull-Rom with doubled coefficients, Horner form
	function automatic longint spline(longint x, longint k0, longint k1,
			longint k2, longint k3);
		longint t;
		t = 3 * (k1 - k2) + (k3 - k0);
		t = rshift_round(t * x, FB) + (2 * k0 - 5 * k1 + 4 * k2 - k3);
		t = rshift_round(t * x, FB) + (k2 - k0);
		t = rshift_round(t * x, FB) + 2 * k1;
		return sat3(rshift_round(t, 1));
	endfunction

	function automatic longint noise_at(int level, int index);
		longint k [4];
		int base;
		if (level == 0) return leaf_level(index);
		base = (index + cur_cell[level - 1]) % 256;
		for (int j = 0; j < 4; j++)
			k[j] = noise_at(level - 1, perm_copy[(base + 255 + j) % 256]);
		return spline(cur_frac[level - 1], k[0], k[1], k[2], k[3]);
	endfunction

	// --- request driver ------------------------------------------------------
	// in_valid stays high past the accepting edge; a next request that waits a gap,
	// or drain(), takes it down at the following falling edge
	task automatic send_request(input logic m, input logic [7:0] addr, val, si,
			input logic [7:0] c0, c1, c2, c3, input logic [15:0] f0, f1, f2, f3);
		int d;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode <= m; load_address <= addr; load_value <= val; start_index <= si;
		cell_0 <= c0; cell_1 <= c1; cell_2 <= c2; cell_3 <= c3;
		frac_0 <= f0; frac_1 <= f1; frac_2 <= f2; frac_3 <= f3;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		// accepted: update the predictor
		if (m == MODE_LOAD) perm_copy[addr] = val;
		else begin
			cur_cell[0] = c0; cur_cell[1] = c1; cur_cell[2] = c2; cur_cell[3] = c3;
			cur_frac[0] = f0; cur_frac[1] = f1; cur_frac[2] = f2; cur_frac[3] = f3;
			d = dims_reg > 4 ? 4 : dims_reg;
			expected_noise.push_back((FB+4)'(noise_at(d, si)));
		end
		@(negedge clk);
	endtask

	task automatic send_eval(input logic [7:0] si, c0, c1, c2, c3,
			input logic [15:0] f0, f1, f2, f3);
		send_request(MODE_EVAL, 8'd0, 8'd0, si, c0, c1, c2, c3, f0, f1, f2, f3);
	endtask

	task automatic send_random_eval();
		logic [15:0] f [4];
		for (int i = 0; i < 4; i++)
			case ($urandom_range(0, 5))
				0: f[i] = 16'h0000;
				1: f[i] = 16'hFFFF;
				default: f[i] = 16'($urandom);
			endcase
		send_eval(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), f[0], f[1], f[2], f[3]);
	endtask

	// wait until every result is in, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_noise.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_dims(input logic [2:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		dims_reg = v;
	endtask

	// --- tests ---------------------------------------------------------------
	task automatic test_table_load();
		// full table, so no unwritten entry is ever read; a random shuffle of 0..255, ends then overwritten
		logic [7:0] p [256];
		int j;
		logic [7:0] t;
		for (int i = 0; i < 256; i++) p[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = int'($urandom_range(0, i));
			t = p[i]; p[i] = p[j]; p[j] = t;
		end
		p[0] = 8'd255; p[255] = 8'd0; // extremes at the extreme addresses
		for (int i = 0; i < 256; i++)
			send_request(MODE_LOAD, 8'(i), p[i], 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
				16'd0, 16'd0, 16'd0, 16'd0);
	endtask

	task automatic test_directed();
		write_dims(3'd0); // zero dimensions: bare leaf value
		send_eval(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_eval(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_eval(8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_eval(8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		write_dims(3'd1);
		send_eval(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 16'd0, 16'd0, 16'd0);
		send_eval(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		send_eval(8'd1, 8'd254, 8'd0, 8'd0, 8'd0, 16'h8000, 16'd0, 16'd0, 16'd0);
		send_eval(8'hAA, 8'h55, 8'd0, 8'd0, 8'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0);
		write_dims(3'd7); // above the maximum: acts as four
		send_eval(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_eval(8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0);
		write_dims(3'd4);
		send_eval(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
			16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
	endtask

	// random traffic at one setting; a few reloads mixed in
	task automatic test_random(input logic [2:0] dims, input int count);
		write_dims(dims);
		for (int n = 0; n < count; n++)
			if ($urandom_range(0, 9) == 0)
				send_request(MODE_LOAD, 8'($urandom), 8'($urandom), 8'd0,
					8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
			else send_random_eval();
	endtask

	// result stalls back up the block while requests keep coming
	task automatic test_backpressure();
		write_dims(3'd1);
		hold_off = 1;
		for (int n = 0; n < 6; n++) send_random_eval();
		hold_off = 0;
	endtask

	// --- result side: stalls and checking -----------------------------------
	int long_stall = 0;
	always @(negedge clk) begin
		if (hold_off && long_stall == 0) long_stall <= 400;
		if (long_stall > 0) begin
			long_stall <= long_stall - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 14) == 0);
	end

	always @(posedge clk) begin
		logic signed [FB+3:0] exp_v;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (expected_noise.size() == 0) begin
				$display("%0t: noise_value expected none actual %0d",
					$time, noise_value);
				failed = 1;
			end else begin
				exp_v = expected_noise.pop_front();
				if (noise_value !== exp_v) begin
					$display("%0t: noise_value expected %0d actual %0d",
						$time, exp_v, noise_value);
					failed = 1;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_table_load();
		test_directed();
		test_backpressure();
		test_random(3'd1, 300);
		test_random(3'd0, 150);
		test_random(3'd2, 500);
		test_random(3'd3, 150);
		test_random(3'd4, 60);
		test_random(3'd2, 150);
		drain();
		if (!failed && expected_noise.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
